### design/ntc_pkg.sv
package ntc_pkg;

    // Fixed field widths
    localparam int CHAR_W      = 8;
    localparam int INT_W       = 64;
    localparam int KIND_W      = 2;
    localparam int ERR_W       = 2;
    localparam int DIGIT_W     = 6;
    localparam int BASE_W      = 7;
    localparam int OUT_TDATA_W = 72;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_E  = 8'h65;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_E  = 8'h45;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;

    // Radix limits and decimal base
    localparam logic [BASE_W-1:0]  BASE_MIN  = 7'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX  = 7'd36;
    localparam logic [BASE_W-1:0]  BASE_SAT  = 7'd127;
    localparam logic [DIGIT_W-1:0] DEC_BASE  = 6'd10;
    localparam logic [DIGIT_W-1:0] NO_DIGIT  = 6'd63;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REAL  = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DEC_OVF   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_RADIX = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RADIX_OVF = 2'd3;

    // Recognizer states
    typedef enum logic [1:0] {
        DEC_START,
        DEC_SIGNED,
        DEC_DIGITS
    } dec_state_t;

    typedef enum logic [2:0] {
        RAD_START,
        RAD_BASE,
        RAD_HASH,
        RAD_FIRST,
        RAD_DIGITS
    } rad_state_t;

    typedef enum logic [3:0] {
        REAL_START,
        REAL_SIGNED,
        REAL_INT,
        REAL_INT_END,
        REAL_DOT_FIRST,
        REAL_FRAC_FIRST,
        REAL_FRAC,
        REAL_EXP_MARK,
        REAL_EXP_SIGN,
        REAL_EXP_FIRST,
        REAL_EXP_DIGITS
    } real_state_t;

    // Character class flags
    typedef struct packed {
        logic sign;
        logic minus;
        logic digit;
        logic dot;
        logic expo;
        logic hash;
        logic alnum;
    } char_class_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        char_class_t cls;
        logic        alpha;
        alpha     = (c >= CHAR_LC_A && c <= CHAR_LC_Z) || (c >= CHAR_UC_A && c <= CHAR_UC_Z);
        cls.sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
        cls.minus = (c == CHAR_MINUS);
        cls.digit = (c >= CHAR_0) && (c <= CHAR_9);
        cls.dot   = (c == CHAR_DOT);
        cls.expo  = (c == CHAR_LC_E) || (c == CHAR_UC_E);
        cls.hash  = (c == CHAR_HASH);
        cls.alnum = cls.digit || alpha;
        return cls;
    endfunction

    // Digit value in bases up to 36; NO_DIGIT for anything else
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CHAR_0 && c <= CHAR_9)
            d = c - CHAR_0;
        else if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
            d = c - CHAR_LC_A + 8'd10;
        else if (c >= CHAR_UC_A && c <= CHAR_UC_Z)
            d = c - CHAR_UC_A + 8'd10;
        return d[DIGIT_W-1:0];
    endfunction

endpackage

### design/numeric_token_classifier.sv
// A last character passes from the input register to the result register, which drives
// the master side; characters that are not last give no result.
// Throughput: one character per cycle; the input register stalls only while a
// result waits on the master side and the held character is a last one.
// Reset (rst_n low, asynchronous) clears both handshake stages and all recognizer
// state; recognizer state also returns to its start after every last character.
module numeric_token_classifier #(
    parameter int VALUE_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ntc_pkg::CHAR_W-1:0]         s_axis_tdata,  // [7:0] char_code
    input  logic                               s_axis_tlast,  // last_char
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ntc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [63:0] int_value,
                                                              // [65:64] error_code
    output logic [ntc_pkg::KIND_W-1:0]         m_axis_tuser   // [1:0] token_kind
);

    localparam int W     = VALUE_BITS;
    localparam int SUM_W = VALUE_BITS + ntc_pkg::DIGIT_W + 1;
    localparam int PAD_W = ntc_pkg::OUT_TDATA_W - ntc_pkg::INT_W - ntc_pkg::ERR_W;

    localparam logic [W-1:0] POS_LIMIT = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_LIMIT = {1'b1, {(W-1){1'b0}}};

    // Input stage
    logic                       in_valid_reg;
    logic [ntc_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_last_reg;
    logic                       advance;

    // Recognizer state
    ntc_pkg::dec_state_t  dec_state_reg,  dec_state_next;
    ntc_pkg::rad_state_t  rad_state_reg,  rad_state_next;
    ntc_pkg::real_state_t real_state_reg, real_state_next;
    logic dec_dead_reg,  dec_dead_next;
    logic rad_dead_reg,  rad_dead_next;
    logic real_dead_reg, real_dead_next;
    logic [W-1:0]                mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic [ntc_pkg::BASE_W-1:0]  base_reg, base_next;
    logic                        ovf_reg, ovf_next;
    logic                        stop_reg, stop_next;

    // Result stage
    logic                       out_valid_reg;
    logic [ntc_pkg::KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [ntc_pkg::INT_W-1:0]  out_value_reg, out_value_next;
    logic [ntc_pkg::ERR_W-1:0]  out_err_reg, out_err_next;

    // Per-character working signals
    ntc_pkg::char_class_t        cls;
    logic [ntc_pkg::DIGIT_W-1:0] dig;
    logic                        dec_acc;
    logic                        rad_step;
    logic                        rad_conv;
    logic                        rad_clear;
    logic                        base_ok;
    logic                        rad_acc;
    logic                        do_acc;
    logic [ntc_pkg::DIGIT_W-1:0] factor;
    logic [SUM_W-1:0]            acc_sum;
    logic [W-1:0]                limit;
    logic [10:0]                 base_sum;

    // Handshake: a last character moves on only when the result slot frees up
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Recognizer transitions and accumulator update
    always_comb
    begin
        cls = ntc_pkg::classify(in_char_reg);
        dig = ntc_pkg::digit_value(in_char_reg);

        dec_state_next  = dec_state_reg;
        dec_dead_next   = dec_dead_reg;
        neg_next        = neg_reg;
        dec_acc         = 1'b0;
        rad_state_next  = rad_state_reg;
        rad_dead_next   = rad_dead_reg;
        rad_step        = 1'b0;
        rad_conv        = 1'b0;
        rad_clear       = 1'b0;
        real_state_next = real_state_reg;
        real_dead_next  = real_dead_reg;

        // signed decimal
        if (!dec_dead_reg)
        begin
            unique case (dec_state_reg)
                ntc_pkg::DEC_START:
                begin
                    if (cls.sign)
                    begin
                        dec_state_next = ntc_pkg::DEC_SIGNED;
                        if (cls.minus)
                            neg_next = 1'b1;
                    end
                    else if (cls.digit)
                    begin
                        dec_state_next = ntc_pkg::DEC_DIGITS;
                        dec_acc        = 1'b1;
                    end
                    else
                        dec_dead_next = 1'b1;
                end
                ntc_pkg::DEC_SIGNED, ntc_pkg::DEC_DIGITS:
                begin
                    if (cls.digit)
                    begin
                        dec_state_next = ntc_pkg::DEC_DIGITS;
                        dec_acc        = 1'b1;
                    end
                    else
                        dec_dead_next = 1'b1;
                end
                default: dec_dead_next = 1'b1;
            endcase
        end

        // radix base#digits
        if (!rad_dead_reg)
        begin
            unique case (rad_state_reg)
                ntc_pkg::RAD_START:
                begin
                    if (cls.digit)
                    begin
                        rad_state_next = ntc_pkg::RAD_BASE;
                        rad_step       = 1'b1;
                    end
                    else
                        rad_dead_next = 1'b1;
                end
                ntc_pkg::RAD_BASE:
                begin
                    if (cls.digit)
                        rad_step = 1'b1;
                    else if (cls.hash)
                    begin
                        rad_state_next = ntc_pkg::RAD_FIRST;
                        rad_clear      = 1'b1;
                    end
                    else
                        rad_dead_next = 1'b1;
                end
                ntc_pkg::RAD_HASH:
                begin
                    if (cls.hash)
                    begin
                        rad_state_next = ntc_pkg::RAD_FIRST;
                        rad_clear      = 1'b1;
                    end
                    else
                        rad_dead_next = 1'b1;
                end
                ntc_pkg::RAD_FIRST, ntc_pkg::RAD_DIGITS:
                begin
                    if (cls.alnum)
                    begin
                        rad_state_next = ntc_pkg::RAD_DIGITS;
                        rad_conv       = 1'b1;
                    end
                    else
                        rad_dead_next = 1'b1;
                end
                default: rad_dead_next = 1'b1;
            endcase
        end

        // real: pass-through states folded into their successors
        if (!real_dead_reg)
        begin
            unique case (real_state_reg)
                ntc_pkg::REAL_START:
                begin
                    if (cls.sign)       real_state_next = ntc_pkg::REAL_SIGNED;
                    else if (cls.digit) real_state_next = ntc_pkg::REAL_INT;
                    else if (cls.dot)   real_state_next = ntc_pkg::REAL_FRAC_FIRST;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_SIGNED:
                begin
                    if (cls.digit)      real_state_next = ntc_pkg::REAL_INT;
                    else if (cls.dot)   real_state_next = ntc_pkg::REAL_FRAC_FIRST;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_INT:
                begin
                    if (cls.digit)      real_state_next = ntc_pkg::REAL_INT;
                    else if (cls.dot)   real_state_next = ntc_pkg::REAL_FRAC;
                    else if (cls.expo)  real_state_next = ntc_pkg::REAL_EXP_SIGN;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_INT_END:
                begin
                    if (cls.dot)        real_state_next = ntc_pkg::REAL_FRAC;
                    else if (cls.expo)  real_state_next = ntc_pkg::REAL_EXP_SIGN;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_DOT_FIRST:
                begin
                    if (cls.dot)        real_state_next = ntc_pkg::REAL_FRAC_FIRST;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_FRAC_FIRST:
                begin
                    if (cls.digit)      real_state_next = ntc_pkg::REAL_FRAC;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_FRAC:
                begin
                    if (cls.digit)      real_state_next = ntc_pkg::REAL_FRAC;
                    else if (cls.expo)  real_state_next = ntc_pkg::REAL_EXP_SIGN;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_EXP_MARK:
                begin
                    if (cls.expo)       real_state_next = ntc_pkg::REAL_EXP_SIGN;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_EXP_SIGN:
                begin
                    if (cls.sign)       real_state_next = ntc_pkg::REAL_EXP_FIRST;
                    else if (cls.digit) real_state_next = ntc_pkg::REAL_EXP_DIGITS;
                    else                real_dead_next  = 1'b1;
                end
                ntc_pkg::REAL_EXP_FIRST, ntc_pkg::REAL_EXP_DIGITS:
                begin
                    if (cls.digit)      real_state_next = ntc_pkg::REAL_EXP_DIGITS;
                    else                real_dead_next  = 1'b1;
                end
                default: real_dead_next = 1'b1;
            endcase
        end

        // base digits, saturating
        base_sum  = 11'(base_reg) * 11'(ntc_pkg::DEC_BASE) + 11'(dig);
        base_next = base_reg;
        if (rad_step)
            base_next = (base_sum > 11'(ntc_pkg::BASE_SAT)) ? ntc_pkg::BASE_SAT
                                                            : base_sum[ntc_pkg::BASE_W-1:0];

        // one multiply-add serves both recognizers; they never convert together
        base_ok = (base_reg >= ntc_pkg::BASE_MIN) && (base_reg <= ntc_pkg::BASE_MAX);
        rad_acc = rad_conv && base_ok && !stop_reg;
        do_acc  = dec_acc || (rad_acc && ({1'b0, dig} < base_reg));
        factor  = dec_acc ? ntc_pkg::DEC_BASE : base_reg[ntc_pkg::DIGIT_W-1:0];
        limit   = (dec_acc && neg_next) ? NEG_LIMIT : POS_LIMIT;
        acc_sum = SUM_W'(mag_reg) * SUM_W'(factor) + SUM_W'(dig);

        mag_next  = mag_reg;
        ovf_next  = ovf_reg;
        stop_next = stop_reg;
        if (rad_acc && ({1'b0, dig} >= base_reg))
            stop_next = 1'b1;
        if (do_acc && !ovf_reg)
        begin
            if (acc_sum > SUM_W'(limit))
                ovf_next = 1'b1;
            else
                mag_next = acc_sum[W-1:0];
        end
        if (rad_clear)
        begin
            mag_next  = '0;
            ovf_next  = 1'b0;
            stop_next = 1'b0;
        end
    end

    // Token verdict from the state after this character
    always_comb
    begin
        out_kind_next  = ntc_pkg::KIND_OTHER;
        out_value_next = '0;
        out_err_next   = ntc_pkg::ERR_NONE;
        if (!dec_dead_next && dec_state_next == ntc_pkg::DEC_DIGITS)
        begin
            out_kind_next = ntc_pkg::KIND_INT;
            if (ovf_next)
                out_err_next = ntc_pkg::ERR_DEC_OVF;
            else
                out_value_next = neg_next ? -ntc_pkg::INT_W'(mag_next)
                                          : ntc_pkg::INT_W'(mag_next);
        end
        else if (!rad_dead_next && rad_state_next == ntc_pkg::RAD_DIGITS)
        begin
            out_kind_next = ntc_pkg::KIND_INT;
            if (!base_ok)
                out_err_next = ntc_pkg::ERR_BAD_RADIX;
            else if (ovf_next)
                out_err_next = ntc_pkg::ERR_RADIX_OVF;
            else
                out_value_next = ntc_pkg::INT_W'(mag_next);
        end
        else if (!real_dead_next && (real_state_next == ntc_pkg::REAL_FRAC ||
                                     real_state_next == ntc_pkg::REAL_EXP_DIGITS))
        begin
            out_kind_next = ntc_pkg::KIND_REAL;
        end
    end

    // Recognizer state registers; back to start after a last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_state_reg  <= ntc_pkg::DEC_START;
            rad_state_reg  <= ntc_pkg::RAD_START;
            real_state_reg <= ntc_pkg::REAL_START;
            dec_dead_reg   <= 1'b0;
            rad_dead_reg   <= 1'b0;
            real_dead_reg  <= 1'b0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            base_reg       <= '0;
            ovf_reg        <= 1'b0;
            stop_reg       <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                dec_state_reg  <= ntc_pkg::DEC_START;
                rad_state_reg  <= ntc_pkg::RAD_START;
                real_state_reg <= ntc_pkg::REAL_START;
                dec_dead_reg   <= 1'b0;
                rad_dead_reg   <= 1'b0;
                real_dead_reg  <= 1'b0;
                mag_reg        <= '0;
                neg_reg        <= 1'b0;
                base_reg       <= '0;
                ovf_reg        <= 1'b0;
                stop_reg       <= 1'b0;
            end
            else
            begin
                dec_state_reg  <= dec_state_next;
                rad_state_reg  <= rad_state_next;
                real_state_reg <= real_state_next;
                dec_dead_reg   <= dec_dead_next;
                rad_dead_reg   <= rad_dead_next;
                real_dead_reg  <= real_dead_next;
                mag_reg        <= mag_next;
                neg_reg        <= neg_next;
                base_reg       <= base_next;
                ovf_reg        <= ovf_next;
                stop_reg       <= stop_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_kind_reg  <= out_kind_next;
            out_value_reg <= out_value_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_err_reg, out_value_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule
